FILE: src/btb_two_way_two_bit_lru_macros.svh
// Assertion macros for the two-way branch target buffer.
// Used by btb_two_way_two_bit_lru; expects clk and arst_n in scope.
`ifndef BTB_TWO_WAY_TWO_BIT_LRU_MACROS_SVH
`define BTB_TWO_WAY_TWO_BIT_LRU_MACROS_SVH

// same-cycle implication
`define BTB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/btb_pkg.sv
// Shared types and constants for the two-way branch target buffer.
// No dependencies.
package btb_pkg;

	localparam int ADDR_W      = 32;
	localparam int SET_LSB     = 11;
	localparam int INSTR_BYTES = 4;

	typedef enum logic [1:0] {
		CTR_STRONG_T  = 2'b00,
		CTR_WEAK_T    = 2'b01,
		CTR_WEAK_NT   = 2'b10,
		CTR_STRONG_NT = 2'b11
	} ctr_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] tag;
		logic [ADDR_W-1:0] target;
		ctr_t              ctr;
	} way_t;

	typedef struct packed {
		way_t [1:0] way;
		logic       recent;
	} row_t;

	typedef struct packed {
		logic hit;
		logic alloc;
		logic coll;
		logic right;
	} res_t;

	localparam int CNT_HIT   = 0;
	localparam int CNT_MISS  = 1;
	localparam int CNT_RIGHT = 2;
	localparam int CNT_WRONG = 3;
	localparam int CNT_COLL  = 4;
	localparam int CNT_NUM   = 5;

endpackage

FILE: src/btb_store.sv
// Set memory of the branch target buffer: one row per set, both ways plus recency.
// Registered read, one write per cycle, clearing pass after reset. Uses btb_pkg.
module btb_store #(
	parameter int SETS  = 512,
	parameter int SET_W = $clog2(SETS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [SET_W-1:0]    rd_addr,
	output btb_pkg::row_t       rd_row,
	input  logic                wr_en,
	input  logic [SET_W-1:0]    wr_addr,
	input  btb_pkg::row_t       wr_row,
	output logic                clearing
);
	import btb_pkg::*;

	row_t             mem [SETS];
	row_t             rd_q;
	logic             clr_active_q;
	logic [SET_W-1:0] clr_idx_q;
	logic             we;
	logic [SET_W-1:0] waddr;
	row_t             wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_idx_q == SET_W'(SETS - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + SET_W'(1);
		end
	end

	always_comb begin
		if (clr_active_q) begin
			we    = 1'b1;
			waddr = clr_idx_q;
			wdata = '0;
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_row   = rd_q;
	assign clearing = clr_active_q;

endmodule

FILE: src/btb_update.sv
// Lookup and training logic for one set row: prediction, hit/allocate, new row.
// Purely combinational. Uses btb_pkg.
module btb_update (
	input  btb_pkg::row_t                 row,
	input  logic [btb_pkg::ADDR_W-1:0]    pc,
	input  logic [btb_pkg::ADDR_W-1:0]    next_pc,
	output btb_pkg::row_t                 new_row,
	output logic [btb_pkg::ADDR_W-1:0]    pred,
	output btb_pkg::res_t                 res
);
	import btb_pkg::*;

	logic [ADDR_W-1:0] seq;
	logic              taken;
	logic              m0;
	logic              m1;
	logic              hit;
	logic              hw;
	logic              aw;
	logic              pt;
	logic              right;
	way_t              cur;
	way_t              nw;

	always_comb begin
		seq   = pc + ADDR_W'(INSTR_BYTES);
		taken = (next_pc != seq);
		m0    = row.way[0].valid && (row.way[0].tag == pc);
		m1    = row.way[1].valid && (row.way[1].tag == pc);
		hit   = m0 || m1;
		hw    = m1;
		cur   = row.way[hw];
		pt    = (cur.ctr == CTR_STRONG_T) || (cur.ctr == CTR_WEAK_T);
		pred  = (hit && pt) ? cur.target : seq;

		nw    = cur;
		right = 1'b0;
		if (taken) begin
			if (pt) begin
				if (cur.target == next_pc) begin
					right  = 1'b1;
					nw.ctr = CTR_STRONG_T;
				end else begin
					nw.target = next_pc;
				end
			end else begin
				nw.ctr = (cur.ctr == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_WEAK_T;
			end
		end else begin
			unique case (cur.ctr)
				CTR_STRONG_T:  nw.ctr = CTR_WEAK_T;
				CTR_WEAK_T:    nw.ctr = CTR_WEAK_NT;
				CTR_WEAK_NT,
				CTR_STRONG_NT: begin
					nw.ctr = CTR_STRONG_NT;
					right  = 1'b1;
				end
			endcase
		end

		// fill an empty way first, else evict the way that is not recent
		priority if (!row.way[0].valid) begin
			aw = 1'b0;
		end else if (!row.way[1].valid) begin
			aw = 1'b1;
		end else begin
			aw = ~row.recent;
		end

		new_row   = row;
		res.hit   = hit;
		res.alloc = !hit && taken;
		res.coll  = !hit && taken && row.way[0].valid && row.way[1].valid;
		res.right = hit && right;
		if (hit) begin
			new_row.way[hw] = nw;
			new_row.recent  = hw;
		end else if (taken) begin
			new_row.way[aw].valid  = 1'b1;
			new_row.way[aw].tag    = pc;
			new_row.way[aw].target = next_pc;
			new_row.way[aw].ctr    = CTR_STRONG_T;
			new_row.recent         = aw;
		end
	end

endmodule

FILE: src/btb_stats.sv
// Saturating event counters of the branch target buffer, low 32 bits exposed.
// Uses btb_pkg for the counter slots.
module btb_stats #(
	parameter int CW = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic [btb_pkg::CNT_NUM-1:0]            inc,
	output logic [btb_pkg::CNT_NUM-1:0][31:0]      count
);
	import btb_pkg::*;

	logic [CW-1:0] cnt_q [CNT_NUM];

	for (genvar i = 0; i < CNT_NUM; i++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (adv && inc[i] && !(&cnt_q[i])) begin
				cnt_q[i] <= cnt_q[i] + CW'(1);
			end
		end
		assign count[i] = 32'(cnt_q[i]);
	end

endmodule

FILE: src/btb_two_way_two_bit_lru.sv
// Two-way set-associative branch target buffer with 2-bit direction counters and
// one recency bit per set. Top level; uses btb_pkg, btb_store, btb_update, btb_stats.
//
// One lookup is accepted per clock cycle while in_stall is low. The set memory is
// read when a lookup is accepted, and the training logic loads the result register
// when the lookup stage advances, which out_stall can hold off. The rate is set by
// the set memory, which reads one row and writes one row each cycle; a lookup to
// the set written in the same cycle is served from a bypass copy of that row.
// After reset the block clears every set, one per cycle, and holds in_stall high
// meanwhile. SETS must be a power of two; the set index is pc bits starting at
// bit 11. Event counts saturate at 2**COUNT_WIDTH - 1 and show their low 32 bits.
`include "btb_two_way_two_bit_lru_macros.svh"

module btb_two_way_two_bit_lru #(
	parameter int SETS        = 512,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pc,
	input  logic [31:0] next_pc,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] predicted_target,
	output logic        lookup_hit,
	output logic        allocated,
	output logic        collision,
	output logic        prediction_right,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count,
	output logic [31:0] right_count,
	output logic [31:0] wrong_count,
	output logic [31:0] collision_count
);
	import btb_pkg::*;

	localparam int SET_W = $clog2(SETS);

	logic                     accept;
	logic                     adv_s1;
	logic                     clearing;
	logic [SET_W-1:0]         in_set;
	logic [SET_W-1:0]         set_s1;
	logic                     v_s1;
	logic [ADDR_W-1:0]        pc_s1;
	logic [ADDR_W-1:0]        npc_s1;
	logic                     byp_hit_s1;
	row_t                     byp_row_s1;
	row_t                     rd_row;
	row_t                     row_s1;
	row_t                     new_row_s1;
	logic [ADDR_W-1:0]        pred_s1;
	res_t                     res_s1;
	logic                     out_valid_q;
	logic [ADDR_W-1:0]        pred_q;
	res_t                     res_q;
	logic [CNT_NUM-1:0]       inc;
	logic [CNT_NUM-1:0][31:0] count;

	assign in_set   = pc[SET_LSB +: SET_W];
	assign set_s1   = pc_s1[SET_LSB +: SET_W];
	assign adv_s1   = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing || (v_s1 && !adv_s1);
	assign accept   = in_valid && !in_stall;
	assign row_s1   = byp_hit_s1 ? byp_row_s1 : rd_row;

	btb_store #(
		.SETS  (SETS),
		.SET_W (SET_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_set),
		.rd_row   (rd_row),
		.wr_en    (adv_s1),
		.wr_addr  (set_s1),
		.wr_row   (new_row_s1),
		.clearing (clearing)
	);

	btb_update u_update (
		.row     (row_s1),
		.pc      (pc_s1),
		.next_pc (npc_s1),
		.new_row (new_row_s1),
		.pred    (pred_s1),
		.res     (res_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			byp_hit_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1       <= 1'b1;
				byp_hit_s1 <= adv_s1 && (in_set == set_s1);
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the word and written-back row for a same-set follower, and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			pc_s1      <= pc;
			npc_s1     <= next_pc;
			byp_row_s1 <= new_row_s1;
		end
		if (adv_s1) begin
			pred_q <= pred_s1;
			res_q  <= res_s1;
		end
	end

	always_comb begin
		inc            = '0;
		inc[CNT_HIT]   = res_s1.hit;
		inc[CNT_MISS]  = res_s1.alloc;
		inc[CNT_RIGHT] = res_s1.right;
		inc[CNT_WRONG] = res_s1.hit && !res_s1.right;
		inc[CNT_COLL]  = res_s1.coll;
	end

	btb_stats #(
		.CW (COUNT_WIDTH)
	) u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_s1),
		.inc    (inc),
		.count  (count)
	);

	assign out_valid        = out_valid_q;
	assign predicted_target = pred_q;
	assign lookup_hit       = res_q.hit;
	assign allocated        = res_q.alloc;
	assign collision        = res_q.coll;
	assign prediction_right = res_q.right;
	assign hit_count        = count[CNT_HIT];
	assign miss_count       = count[CNT_MISS];
	assign right_count      = count[CNT_RIGHT];
	assign wrong_count      = count[CNT_WRONG];
	assign collision_count  = count[CNT_COLL];

	`BTB_ASSERT_IMPL(a_coll_full_set, adv_s1 && res_s1.coll, res_s1.alloc && row_s1.way[0].valid && row_s1.way[1].valid, "collision without a full set")
	`BTB_ASSERT_IMPL(a_no_dup_tag, adv_s1 && new_row_s1.way[0].valid && new_row_s1.way[1].valid, new_row_s1.way[0].tag != new_row_s1.way[1].tag, "same tag in both ways")
	`BTB_ASSERT_NEXT(a_counts_hold, !adv_s1, $stable(hit_count) && $stable(miss_count) && $stable(wrong_count), "counts moved without a word")

endmodule
